// ===== rtl/vfra_pkg.sv =====
`timescale 1ns / 1ps

package vfra_pkg;

  // Fixed field widths of the streaming payload.
  localparam int SIZE_W      = 21;  // frame size and record address fields
  localparam int COUNT_W     = 11;  // frames_discarded and frames_held fields
  localparam int LEN_W       = 22;  // header + payload + spare byte
  localparam int SUM_W       = 23;  // pointer + record length, no overflow
  localparam int TDATA_IN_W  = 24;
  localparam int TDATA_OUT_W = 64;

  typedef enum logic [1:0] {
    ST_PUSHED    = 2'd0,
    ST_POPPED    = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DROP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] frames_held;
    logic [COUNT_W-1:0] frames_discarded;
    logic [SIZE_W-1:0]  popped_size;
    logic [SIZE_W-1:0]  record_address;
    status_t            status;
  } res_t;

endpackage

// ===== rtl/vfra_ram.sv =====
`timescale 1ns / 1ps

module vfra_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/vfra_ctrl.sv =====
`timescale 1ns / 1ps

module vfra_ctrl #(
  parameter int BUFFER_BYTES = 2097152,
  parameter int HEADER_BYTES = 8,
  parameter int MAX_FRAMES   = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [vfra_pkg::SIZE_W-1:0]   frame_size,
  output logic                          res_valid,
  input  logic                          res_ready,
  output vfra_pkg::res_t                res,
  output logic                          rd_en,
  output logic [$clog2(MAX_FRAMES)-1:0] rd_addr,
  input  logic [vfra_pkg::SIZE_W-1:0]   rd_data,
  output logic                          wr_en,
  output logic [$clog2(MAX_FRAMES)-1:0] wr_addr,
  output logic [vfra_pkg::SIZE_W-1:0]   wr_data
);

  import vfra_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_FRAMES);
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  state_t             state, state_next;
  logic [PTR_W-1:0]   wp, wp_next;
  logic [PTR_W-1:0]   rp, rp_next;
  logic [PTR_W-1:0]   wrap, wrap_next;
  logic [IDX_W-1:0]   oldest, oldest_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   dropped, dropped_next;
  logic               is_pop, is_pop_next;
  logic [LEN_W-1:0]   len, len_next;
  logic [SIZE_W-1:0]  fsize, fsize_next;
  res_t               res_q, res_fin;

  logic [LEN_W-1:0]   len_in;
  logic [SUM_W-1:0]   wp_sum, rp_sum, buf_sz, place_sum;
  logic [IDX_W:0]     slot_sum;
  logic [IDX_W-1:0]   oldest_inc;
  logic [PTR_W-1:0]   wp_eff;
  logic               place, finish;

  assign len_in  = LEN_W'(HEADER_BYTES) + LEN_W'(frame_size) + LEN_W'(1);
  assign wp_sum  = SUM_W'(wp) + SUM_W'(len);
  assign rp_sum  = SUM_W'(rp) + SUM_W'(HEADER_BYTES) + SUM_W'(rd_data) + SUM_W'(1);
  assign buf_sz  = SUM_W'(BUFFER_BYTES);
  assign slot_sum = (IDX_W + 1)'(oldest) + (IDX_W + 1)'(count);
  assign oldest_inc = (oldest == IDX_W'(MAX_FRAMES - 1)) ? '0 : oldest + IDX_W'(1);
  assign place_sum = SUM_W'(wp_eff) + SUM_W'(len);

  // Entries are read only after an earlier push wrote them, so read and write
  // never meet on one entry in the same cycle.
  assign rd_addr = oldest;
  assign wr_data = fsize;
  assign wr_addr = (slot_sum >= (IDX_W + 1)'(MAX_FRAMES)) ?
                   IDX_W'(slot_sum - (IDX_W + 1)'(MAX_FRAMES)) : IDX_W'(slot_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      wp     <= '0;
      rp     <= '0;
      wrap   <= PTR_W'(BUFFER_BYTES);
      oldest <= '0;
      count  <= '0;
    end else begin
      state  <= state_next;
      wp     <= wp_next;
      rp     <= rp_next;
      wrap   <= wrap_next;
      oldest <= oldest_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    dropped <= dropped_next;
    is_pop  <= is_pop_next;
    len     <= len_next;
    fsize   <= fsize_next;
    if (finish) begin
      res_q <= res_fin;
    end
  end

  always_comb begin
    state_next   = state;
    wp_next      = wp;
    rp_next      = rp;
    wrap_next    = wrap;
    oldest_next  = oldest;
    count_next   = count;
    dropped_next = dropped;
    is_pop_next  = is_pop;
    len_next     = len;
    fsize_next   = fsize;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    place        = 1'b0;
    wp_eff       = wp;
    finish       = 1'b0;
    res_fin      = '0;
    in_ready     = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          is_pop_next  = req_type;
          fsize_next   = frame_size;
          len_next     = len_in;
          dropped_next = '0;
          if (req_type) begin
            if (count == '0) begin
              finish              = 1'b1;
              res_fin.status      = ST_EMPTY;
              res_fin.frames_held = COUNT_W'(count);
            end else begin
              rd_en      = 1'b1;
              state_next = S_DROP;
            end
          end else if (SUM_W'(len_in) > buf_sz) begin
            finish              = 1'b1;
            res_fin.status      = ST_TOO_LARGE;
            res_fin.frames_held = COUNT_W'(count);
          end else begin
            state_next = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        priority if (count == CNT_W'(MAX_FRAMES)) begin
          // descriptor store full: drop the oldest first
          rd_en      = 1'b1;
          state_next = S_DROP;
        end else if (count == '0) begin
          wp_eff    = (wp_sum > buf_sz) ? '0 : wp;
          rp_next   = wp_eff;
          wrap_next = PTR_W'(BUFFER_BYTES);
          place     = 1'b1;
        end else if (wp > rp) begin
          if (wp_sum <= buf_sz) begin
            place = 1'b1;
          end else begin
            wrap_next = wp;
            wp_next   = '0;
          end
        end else if (wp_sum <= SUM_W'(rp)) begin
          place = 1'b1;
        end else begin
          rd_en      = 1'b1;
          state_next = S_DROP;
        end
      end

      S_DROP: begin
        if (rp_sum >= SUM_W'(wrap)) begin
          rp_next   = '0;
          wrap_next = PTR_W'(BUFFER_BYTES);
        end else begin
          rp_next = PTR_W'(rp_sum);
        end
        oldest_next = oldest_inc;
        count_next  = count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          rp_next   = wp;
          wrap_next = PTR_W'(BUFFER_BYTES);
        end
        if (is_pop) begin
          finish                 = 1'b1;
          res_fin.status         = ST_POPPED;
          res_fin.record_address = SIZE_W'(rp);
          res_fin.popped_size    = rd_data;
          res_fin.frames_held    = COUNT_W'(count - CNT_W'(1));
        end else begin
          dropped_next = dropped + CNT_W'(1);
          state_next   = S_CHECK;
        end
      end

      S_DONE: begin
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (place) begin
      wr_en                    = 1'b1;
      count_next               = count + CNT_W'(1);
      wp_next                  = PTR_W'(place_sum);
      finish                   = 1'b1;
      res_fin.status           = ST_PUSHED;
      res_fin.record_address   = SIZE_W'(wp_eff);
      res_fin.frames_discarded = COUNT_W'(dropped);
      res_fin.frames_held      = COUNT_W'(count + CNT_W'(1));
    end

    res_valid = finish || (state == S_DONE);
    res       = (state == S_DONE) ? res_q : res_fin;
    if (res_valid) begin
      state_next = res_ready ? S_IDLE : S_DONE;
    end
  end

endmodule

// ===== rtl/vfra_obuf.sv =====
`timescale 1ns / 1ps

module vfra_obuf (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  vfra_pkg::res_t                   in_res,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [1:0]                       m_tuser,
  output logic [vfra_pkg::TDATA_OUT_W-1:0] m_tdata
);

  import vfra_pkg::*;

  assign in_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      m_tuser <= in_res.status;
      m_tdata <= {in_res.frames_held, in_res.frames_discarded,
                  in_res.popped_size, in_res.record_address};
    end
  end

endmodule

// ===== rtl/variable_frame_ring_allocator.sv =====
`timescale 1ns / 1ps

// Address allocator for a circular frame buffer of BUFFER_BYTES bytes. Each
// request on the slave stream is a push (s_tuser = 0, s_tdata = payload size)
// or a pop (s_tuser = 1), and each gives exactly one transfer on the master
// stream: status in m_tuser (0 pushed, 1 popped, 2 pop while empty, 3 push too
// large) and the header address, popped size, count of frames dropped for the
// push and frames held after the request in m_tdata. A record occupies
// HEADER_BYTES + size + 1 bytes, never straddles the buffer end (it wraps
// early and the wrap point is kept), and the oldest frames are dropped until a
// new record fits or when MAX_FRAMES descriptors are already held. Payload
// sizes live in a MAX_FRAMES-deep RAM with a registered read; no clearing
// pass is needed after reset. A pop while empty or an oversize push completes
// in the idle state, a pop after one descriptor RAM read and pointer update,
// and a push after a fit check, with one descriptor RAM read and pointer
// update for every dropped frame and one more check after an early wrap. One
// request is worked on at a time; the next is taken as soon as the result is
// in the output register, which holds it while the master side stalls.
module variable_frame_ring_allocator #(
  parameter int BUFFER_BYTES = 2097152,
  parameter int HEADER_BYTES = 8,
  parameter int MAX_FRAMES   = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [vfra_pkg::TDATA_IN_W-1:0]  s_tdata,   // [20:0] frame_size, rest zero
  input  logic                             s_tuser,   // [0] req_type
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [vfra_pkg::TDATA_OUT_W-1:0] m_tdata,   // [20:0] record_address,
                                                      // [41:21] popped_size,
                                                      // [52:42] frames_discarded,
                                                      // [63:53] frames_held
  output logic [1:0]                       m_tuser    // [1:0] status
);

  import vfra_pkg::*;

  localparam int IDX_W = $clog2(MAX_FRAMES);

  logic              res_valid, res_ready;
  res_t              res;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [SIZE_W-1:0] rd_data, wr_data;

  // Sequencer: pointers, wrap point, drop loop and descriptor bookkeeping.
  vfra_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_FRAMES  (MAX_FRAMES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req_type  (s_tuser),
    .frame_size(s_tdata[SIZE_W-1:0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Payload size of each stored frame, indexed by descriptor slot.
  vfra_ram #(
    .WIDTH(SIZE_W),
    .DEPTH(MAX_FRAMES)
  ) u_sizes (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Output register: hold the result until the master side takes the transfer.
  vfra_obuf u_obuf (
    .clk     (clk),
    .rst     (rst),
    .in_valid(res_valid),
    .in_ready(res_ready),
    .in_res  (res),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tuser (m_tuser),
    .m_tdata (m_tdata)
  );

endmodule

// ===== tb/tb_variable_frame_ring_allocator.sv =====
`timescale 1ns / 1ps

module tb_variable_frame_ring_allocator;
  import vfra_pkg::*;

  localparam int BUFFER_BYTES = 2097152;
  localparam int HEADER_BYTES = 8;
  localparam int MAX_FRAMES   = 1024;

  localparam int FILL_ITEMS    = 1100;  // push-heavy run that reaches a full descriptor store
  localparam int CHURN_ITEMS   = 250;   // wide sizes and frequent pops
  localparam int PHASE_B_START = 450;
  localparam int PHASE_C_START = 900;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 64;
  localparam int QUIET_LIMIT   = 20000; // long enough for a push that drops every frame
  localparam int REPORT_LIMIT  = 10;

  typedef enum bit {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef struct {
    req_t              req;
    logic [SIZE_W-1:0] size;
    bit                typed;  // expectation written in the row itself
    res_t              want;
  } dir_row_t;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata  = '0;   // [20:0] frame_size, rest zero
  logic                   s_tuser  = 1'b0; // [0] req_type
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;         // [20:0] record_address, [41:21] popped_size,
                                           // [52:42] frames_discarded, [63:53] frames_held
  logic [1:0]             m_tuser;         // [1:0] status

  // Ring state of the predictor.
  logic [LEN_W-1:0]   wr_ptr;
  logic [LEN_W-1:0]   rd_ptr;
  logic [LEN_W-1:0]   wrap_pt;
  logic [SIZE_W-1:0]  frame_len_store [MAX_FRAMES];
  logic [9:0]         oldest;
  logic [COUNT_W-1:0] held;

  res_t     pending_allocs[$];
  dir_row_t dir_rows[$];

  int snd_idle      = 21;
  int rcv_idle      = 80;
  int stall_request = 0;
  int stall_left    = 0;
  int quiet_cycles  = 0;
  int errors        = 0;
  int status_seen[4];
  int total_dropped = 0;
  int peak_held     = 0;

  variable_frame_ring_allocator #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_FRAMES  (MAX_FRAMES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #1 clk = ~clk;

  function automatic void log_error(string msg);
    errors++;
    if (errors <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endfunction

  // Release the oldest record; the store is never empty when this runs.
  function automatic void retire_oldest();
    rd_ptr = rd_ptr + LEN_W'(HEADER_BYTES) + LEN_W'(frame_len_store[oldest]) + 1'b1;
    if (rd_ptr >= wrap_pt) begin
      rd_ptr  = '0;
      wrap_pt = LEN_W'(BUFFER_BYTES);
    end
    oldest = oldest + 1'b1;
    held   = held - 1'b1;
    // Last frame gone: collapse the ring onto the write pointer.
    if (held == 0) begin
      rd_ptr  = wr_ptr;
      wrap_pt = LEN_W'(BUFFER_BYTES);
    end
  endfunction

  function automatic res_t predict_allocation(req_t req, logic [SIZE_W-1:0] fsize);
    res_t             r;
    logic [LEN_W-1:0] rec_len;
    int               guard;
    r = '0;
    if (req == REQ_POP) begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status         = ST_POPPED;
        r.record_address = rd_ptr[SIZE_W-1:0];
        r.popped_size    = frame_len_store[oldest];
        retire_oldest();
      end
    end else begin
      rec_len = LEN_W'(HEADER_BYTES) + LEN_W'(fsize) + 1'b1;
      if (rec_len > BUFFER_BYTES) begin
        r.status = ST_TOO_LARGE;
      end else begin
        r.status = ST_PUSHED;
        // Descriptor store full: make a slot first.
        if (held >= MAX_FRAMES) begin
          retire_oldest();
          r.frames_discarded = r.frames_discarded + 1'b1;
        end
        for (guard = 0; guard < 2 * MAX_FRAMES + 8; guard++) begin
          if (held == 0) begin
            if (wr_ptr + rec_len > BUFFER_BYTES) wr_ptr = '0;
            rd_ptr  = wr_ptr;
            wrap_pt = LEN_W'(BUFFER_BYTES);
            break;
          end
          if (wr_ptr > rd_ptr) begin
            if (wr_ptr + rec_len <= BUFFER_BYTES) break;
            // Wrap early and remember where the data ends.
            wrap_pt = wr_ptr;
            wr_ptr  = '0;
          end else begin
            if (wr_ptr + rec_len <= rd_ptr) break;
            retire_oldest();
            r.frames_discarded = r.frames_discarded + 1'b1;
          end
        end
        r.record_address = wr_ptr[SIZE_W-1:0];
        frame_len_store[10'(oldest + held)] = fsize;
        held   = held + 1'b1;
        wr_ptr = wr_ptr + rec_len;
      end
    end
    r.frames_held = held;
    status_seen[r.status]++;
    total_dropped += r.frames_discarded;
    if (held > peak_held) peak_held = held;
    return r;
  endfunction

  function automatic void add_row(req_t req, int size, bit typed, status_t st, int addr,
                                  int frames);
    dir_row_t row;
    row.req                  = req;
    row.size                 = SIZE_W'(size);
    row.typed                = typed;
    row.want                 = '0;
    row.want.status          = st;
    row.want.record_address  = SIZE_W'(addr);
    row.want.frames_held     = COUNT_W'(frames);
    dir_rows.push_back(row);
  endfunction

  // Offer one request, hold it until the transfer, then record what it owes.
  task automatic send_request(req_t req, logic [SIZE_W-1:0] fsize, bit typed, res_t want);
    res_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_IN_W'(fsize);
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    predicted = predict_allocation(req, fsize);
    pending_allocs.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait for every owed result.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_allocs.size() != 0) @(posedge clk);
  endtask

  // Receiver: random back-pressure, or a counted hold-off when asked.
  always @(negedge clk) begin
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Result checker against the oldest owed allocation.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata, m_tuser};
      if (pending_allocs.size() == 0) begin
        log_error($sformatf("unexpected result: status %0d addr %0d", got.status,
                            got.record_address));
      end else begin
        want = pending_allocs.pop_front();
        if (got.status !== want.status || got.record_address !== want.record_address ||
            got.popped_size !== want.popped_size ||
            got.frames_discarded !== want.frames_discarded ||
            got.frames_held !== want.frames_held)
          log_error($sformatf({"mismatch exp/act: status %0d/%0d addr %0d/%0d ",
                               "size %0d/%0d dropped %0d/%0d held %0d/%0d"},
                              want.status, got.status, want.record_address,
                              got.record_address, want.popped_size, got.popped_size,
                              want.frames_discarded, got.frames_discarded,
                              want.frames_held, got.frames_held));
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int                n;
    int                pick;
    req_t              req;
    logic [SIZE_W-1:0] fsize;

    wr_ptr  = '0;
    rd_ptr  = '0;
    wrap_pt = LEN_W'(BUFFER_BYTES);
    oldest  = '0;
    held    = '0;
    foreach (frame_len_store[i]) frame_len_store[i] = '0;

    // Directed rows: empty pop, size limit on both sides, a record filling the whole
    // buffer, early wrap with drops, and alternating bit patterns.
    add_row(REQ_POP,  0,       1, ST_EMPTY,     0, 0);
    add_row(REQ_PUSH, 2097151, 1, ST_TOO_LARGE, 0, 0);
    add_row(REQ_PUSH, 2097144, 1, ST_TOO_LARGE, 0, 0);
    add_row(REQ_PUSH, 2097143, 1, ST_PUSHED,    0, 1);
    add_row(REQ_PUSH, 2097144, 1, ST_TOO_LARGE, 0, 1);
    add_row(REQ_PUSH, 0,       0, ST_PUSHED,    0, 0);
    add_row(REQ_POP,  0,       0, ST_PUSHED,    0, 0);
    add_row(REQ_POP,  0,       1, ST_EMPTY,     0, 0);
    add_row(REQ_PUSH, 100,     0, ST_PUSHED,    0, 0);
    add_row(REQ_PUSH, 'h155555, 0, ST_PUSHED,   0, 0);
    add_row(REQ_PUSH, 'h0AAAAA, 0, ST_PUSHED,   0, 0);
    add_row(REQ_PUSH, 1000000, 0, ST_PUSHED,    0, 0);
    add_row(REQ_PUSH, 1000000, 0, ST_PUSHED,    0, 0);
    add_row(REQ_POP,  0,       0, ST_PUSHED,    0, 0);
    add_row(REQ_PUSH, 0,       0, ST_PUSHED,    0, 0);
    add_row(REQ_PUSH, 500000,  0, ST_PUSHED,    0, 0);
    add_row(REQ_PUSH, 1,       0, ST_PUSHED,    0, 0);
    add_row(REQ_POP,  0,       0, ST_PUSHED,    0, 0);
    add_row(REQ_PUSH, 2097143, 0, ST_PUSHED,    0, 0);
    add_row(REQ_PUSH, 2097151, 0, ST_PUSHED,    0, 0);
    add_row(REQ_PUSH, 63,      0, ST_PUSHED,    0, 0);
    add_row(REQ_POP,  0,       0, ST_PUSHED,    0, 0);
    add_row(REQ_POP,  0,       0, ST_PUSHED,    0, 0);
    add_row(REQ_POP,  0,       0, ST_PUSHED,    0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].size, dir_rows[i].typed, dir_rows[i].want);

    for (n = 0; n < FILL_ITEMS + CHURN_ITEMS; n++) begin
      if (n == PHASE_B_START) begin
        wait_drained();
        snd_idle = 80;
        rcv_idle = 21;
      end
      if (n == PHASE_C_START) begin
        wait_drained();
        snd_idle = 0;
        rcv_idle = 0;
        // Long hold-off while requests keep coming.
        stall_request = HOLD_CYCLES;
      end
      if (n < FILL_ITEMS) begin
        // Mostly small pushes: climbs past the descriptor limit.
        req   = ($urandom_range(0, 99) < 1) ? REQ_POP : REQ_PUSH;
        fsize = ($urandom_range(0, 99) < 2) ? SIZE_W'($urandom_range(0, 65535))
                                            : SIZE_W'($urandom_range(0, 63));
      end else begin
        req  = ($urandom_range(0, 99) < 50) ? REQ_POP : REQ_PUSH;
        pick = $urandom_range(0, 99);
        if (pick < 35)      fsize = SIZE_W'($urandom_range(0, 255));
        else if (pick < 65) fsize = SIZE_W'($urandom_range(0, 65535));
        else if (pick < 90) fsize = SIZE_W'($urandom_range(0, 2097151));
        else                fsize = SIZE_W'($urandom_range(2097130, 2097151));
      end
      send_request(req, fsize, 1'b0, '0);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_allocs.size() != 0)
      log_error($sformatf("%0d results never arrived", pending_allocs.size()));

    $display("covered %0d pushes, %0d pops, %0d empty pops, %0d oversize rejects",
             status_seen[ST_PUSHED], status_seen[ST_POPPED], status_seen[ST_EMPTY],
             status_seen[ST_TOO_LARGE]);
    $display("frames dropped %0d, peak frames held %0d, mismatches %0d",
             total_dropped, peak_held, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
